@@ rtl/ibbm_pkg.sv @@
// Shared types and constants of the idle backlight and battery manager.
package ibbm_pkg;

	// Display power states
	typedef enum logic [1:0] {
		DS_BRIGHT = 2'd0,
		DS_DIM    = 2'd1,
		DS_ASLEEP = 2'd2
	} disp_t;

	// Sequencer states
	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SMOOTH,
		CS_PCT,
		CS_PCT_WAIT,
		CS_FIN
	} ctl_t;

	// Configuration register indexes
	localparam logic [2:0] REG_IDLE_DIM   = 3'd0;
	localparam logic [2:0] REG_IDLE_SLEEP = 3'd1;
	localparam logic [2:0] REG_USER_BRT   = 3'd2;
	localparam logic [2:0] REG_DIM_LEVEL  = 3'd3;
	localparam logic [2:0] REG_FULL_MV    = 3'd4;
	localparam logic [2:0] REG_EMPTY_MV   = 3'd5;
	localparam logic [2:0] REG_LOW_MV     = 3'd6;
	localparam logic [2:0] REG_DIVIDER    = 3'd7;

	// Divider geometry
	localparam int DIV_W = 22;
	localparam int DVS_W = 16;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic [15:0] KNEE_MV          = 16'd3700;
	localparam logic [6:0]  HALF_PCT         = 7'd50;
	localparam logic [6:0]  FULL_PCT         = 7'd100;
	localparam logic [31:0] SAMPLE_PERIOD_MS = 32'd30000;
	localparam logic [31:0] WAKE_MASK_MS     = 32'd100;
	localparam logic [31:0] SLEEP_MASK_MS    = 32'd400;
	localparam logic [7:0]  MIN_BRIGHTNESS   = 8'd5;
	localparam logic [15:0] SMOOTH_DIVISOR   = 16'd5;
	localparam logic [21:0] PCT_SCALE        = 22'd50;

	// 2^22/5 rounded up: (x * SMOOTH_RECIP) >> RECIP_SHIFT is x/5 for any 22-bit x
	localparam logic [19:0] SMOOTH_RECIP     = 20'd838861;
	localparam int          RECIP_SHIFT      = 22;

	// Request into the divider
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

endpackage

@@ rtl/idle_backlight_and_battery_manager_unit.sv @@
// Top level of the idle backlight and battery manager.
//
// Usage: each tick item on the s_ channel carries the current time, the latest
// touch-activity stamp, USB presence and a battery pin sample. For every tick
// one result item leaves on the m_ channel: display state, backlight level,
// panel wake/sleep pulses, touch mask time and the battery report.
// The display state is updated in the cycle the item is taken. When a sample is
// due on a seeded value, the (4*old+new)/5 blend follows in the CS_SMOOTH state as a
// multiply by the reciprocal of 5. The percent, when the value lies strictly
// between empty and full, runs on one restoring divider, which forms the
// quotient bit by bit before the CS_PCT_WAIT state takes it.
// s_tready is low from acceptance until the result is registered, so a new
// item is never taken before the last one's result is registered. The next
// item is taken as soon as the result is registered, even if the receiver
// still stalls it; a stalled result holds in the output register and blocks
// only the next result from being loaded.
// Registers are to be written over wr_en/wr_idx/wr_data only while the block
// is idle; the block itself does not enforce this.
// Reset puts the configuration registers at their documented defaults, the
// display bright, the battery value unseeded and the output channel empty.
module idle_backlight_and_battery_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms[31:0], activity_stamp_ms[63:32], usb_present[64], pin_mv[76:65], zeros
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// power_state[1:0], backlight_level[9:2], panel_wake[10], panel_sleep[11],
	// touch_mask_until_ms[43:12], battery_mv[59:44], battery_pct[66:60],
	// battery_low[67], charging[68], zeros
	output logic [71:0] m_tdata,
	input  logic        wr_en,
	input  logic [2:0]  wr_idx,
	input  logic [31:0] wr_data
);

	// configuration
	logic [31:0] idle_dim_q, idle_sleep_q;
	logic [7:0]  user_brt_q, dim_level_q;
	logic [15:0] full_mv_q, low_mv_q;
	logic [11:0] empty_mv_q;
	logic [3:0]  divider_q;

	// block state
	ibbm_pkg::disp_t disp_q;
	logic [31:0] last_seen_q, prev_stamp_q, last_sample_q, mask_q;
	logic [15:0] smoothed_q;
	logic        sampled_q;

	// per-item results awaiting the battery work
	logic [7:0]  level_q;
	logic        wake_q, sleep_q, charging_q;
	logic [6:0]  pct_q;
	logic        pct_upper_q;
	logic [21:0] blend_q;

	// output register
	logic        m_valid_q;
	logic [71:0] m_data_q;

	ibbm_pkg::ctl_t ctl_q, ctl_d;

	// input fields
	logic [31:0] now_ms, stamp_ms;
	logic        usb;
	logic [11:0] pin_mv;

	assign now_ms   = s_tdata[31:0];
	assign stamp_ms = s_tdata[63:32];
	assign usb      = s_tdata[64];
	assign pin_mv   = s_tdata[76:65];

	logic accept;
	assign accept = s_tvalid && s_tready;

	// --- sample decision and raw sample
	logic        sample_due;
	logic [31:0] since_sample;
	logic [15:0] raw_mv;
	logic [21:0] blend_num;

	assign since_sample = now_ms - last_sample_q;
	assign sample_due   = !sampled_q || (since_sample >= ibbm_pkg::SAMPLE_PERIOD_MS);
	assign raw_mv       = 16'(pin_mv) * 16'(divider_q);
	assign blend_num    = {4'b0, smoothed_q, 2'b00} + 22'(raw_mv);

	// --- display update, settled within the accept cycle
	logic            act, wake_now, sleep_now;
	ibbm_pkg::disp_t st_act, st_new;
	logic [31:0]     seen_new, idle_ms, mask_new;
	logic [7:0]      level_new;

	always_comb begin
		act       = (stamp_ms != prev_stamp_q) || usb;
		wake_now  = act && (disp_q == ibbm_pkg::DS_ASLEEP);
		st_act    = act ? ibbm_pkg::DS_BRIGHT : disp_q;
		seen_new  = act ? now_ms : last_seen_q;
		idle_ms   = now_ms - seen_new;
		mask_new  = wake_now ? (now_ms + ibbm_pkg::WAKE_MASK_MS) : mask_q;
		sleep_now = 1'b0;
		st_new    = st_act;
		if (!usb) begin
			case (st_act)
				ibbm_pkg::DS_DIM: begin
					if (idle_ms >= idle_sleep_q) begin
						st_new    = ibbm_pkg::DS_ASLEEP;
						sleep_now = 1'b1;
						mask_new  = now_ms + ibbm_pkg::SLEEP_MASK_MS;
					end
				end
				ibbm_pkg::DS_ASLEEP: st_new = st_act;
				default: begin
					if (idle_ms >= idle_dim_q) st_new = ibbm_pkg::DS_DIM;
				end
			endcase
		end
		case (st_new)
			ibbm_pkg::DS_DIM:    level_new = dim_level_q;
			ibbm_pkg::DS_ASLEEP: level_new = '0;
			default:             level_new = user_brt_q;
		endcase
	end

	// --- percent case selection on the settled smoothed value
	logic        pct_full, pct_empty, pct_lower;
	logic [15:0] pct_diff, pct_span;
	logic [21:0] pct_num;

	always_comb begin
		pct_full  = smoothed_q >= full_mv_q;
		pct_empty = smoothed_q <= 16'(empty_mv_q);
		pct_lower = smoothed_q <= ibbm_pkg::KNEE_MV;
		if (pct_lower) begin
			pct_diff = smoothed_q - 16'(empty_mv_q);
			pct_span = ibbm_pkg::KNEE_MV - 16'(empty_mv_q);
		end else begin
			pct_diff = smoothed_q - ibbm_pkg::KNEE_MV;
			pct_span = full_mv_q - ibbm_pkg::KNEE_MV;
		end
		pct_num = 22'(pct_diff) * ibbm_pkg::PCT_SCALE;
	end

	// --- divider
	ibbm_pkg::div_req_t div_req;
	logic               div_done;
	logic [21:0]        div_quo;

	ibbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// --- blend: divide the held 4*old+new by 5 through its reciprocal
	logic [41:0] blend_prod;
	logic [19:0] blend_quo;
	logic [15:0] blend_sat;

	assign blend_prod = 42'(blend_q) * 42'(ibbm_pkg::SMOOTH_RECIP);
	assign blend_quo  = blend_prod[ibbm_pkg::RECIP_SHIFT +: 20];
	assign blend_sat  = (blend_quo > 20'd65535) ? 16'hFFFF : blend_quo[15:0];

	logic out_free;
	assign out_free = !m_valid_q || m_tready;

	// --- sequencer: next state
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			ibbm_pkg::CS_IDLE: begin
				if (accept) begin
					ctl_d = (sample_due && smoothed_q != '0) ? ibbm_pkg::CS_SMOOTH
					                                          : ibbm_pkg::CS_PCT;
				end
			end
			ibbm_pkg::CS_SMOOTH:   ctl_d = ibbm_pkg::CS_PCT;
			ibbm_pkg::CS_PCT: begin
				ctl_d = (pct_full || pct_empty) ? ibbm_pkg::CS_FIN : ibbm_pkg::CS_PCT_WAIT;
			end
			ibbm_pkg::CS_PCT_WAIT: if (div_done) ctl_d = ibbm_pkg::CS_FIN;
			ibbm_pkg::CS_FIN:      if (out_free) ctl_d = ibbm_pkg::CS_IDLE;
			default:               ctl_d = ibbm_pkg::CS_IDLE;
		endcase
	end

	// --- sequencer: outputs
	logic out_load;

	always_comb begin
		s_tready         = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = pct_num;
		div_req.divisor  = pct_span;
		case (ctl_q)
			ibbm_pkg::CS_IDLE: s_tready = 1'b1;
			ibbm_pkg::CS_PCT:  div_req.start = !(pct_full || pct_empty);
			ibbm_pkg::CS_FIN:  out_load = out_free;
			default: ;
		endcase
	end

	// --- control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= ibbm_pkg::CS_IDLE;
			idle_dim_q    <= 32'd15000;
			idle_sleep_q  <= 32'd30000;
			user_brt_q    <= 8'd200;
			dim_level_q   <= 8'd20;
			full_mv_q     <= 16'd4150;
			empty_mv_q    <= 12'd3300;
			low_mv_q      <= 16'd3450;
			divider_q     <= 4'd2;
			disp_q        <= ibbm_pkg::DS_BRIGHT;
			last_seen_q   <= '0;
			prev_stamp_q  <= '0;
			last_sample_q <= '0;
			mask_q        <= '0;
			smoothed_q    <= '0;
			sampled_q     <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			ctl_q <= ctl_d;

			if (wr_en) begin
				case (wr_idx)
					ibbm_pkg::REG_IDLE_DIM:   idle_dim_q   <= wr_data;
					ibbm_pkg::REG_IDLE_SLEEP: idle_sleep_q <= wr_data;
					ibbm_pkg::REG_USER_BRT: begin
						// clamp so the bright level never goes dark
						user_brt_q <= (wr_data[7:0] < ibbm_pkg::MIN_BRIGHTNESS)
						            ? ibbm_pkg::MIN_BRIGHTNESS : wr_data[7:0];
					end
					ibbm_pkg::REG_DIM_LEVEL:  dim_level_q <= wr_data[7:0];
					ibbm_pkg::REG_FULL_MV:    full_mv_q   <= wr_data[15:0];
					ibbm_pkg::REG_EMPTY_MV:   empty_mv_q  <= wr_data[11:0];
					ibbm_pkg::REG_LOW_MV:     low_mv_q    <= wr_data[15:0];
					ibbm_pkg::REG_DIVIDER:    divider_q   <= wr_data[3:0];
					default: ;
				endcase
			end

			if (accept) begin
				prev_stamp_q <= stamp_ms;
				last_seen_q  <= seen_new;
				disp_q       <= st_new;
				mask_q       <= mask_new;
				if (sample_due) begin
					sampled_q     <= 1'b1;
					last_sample_q <= now_ms;
					// unseeded value takes the raw sample directly
					if (smoothed_q == '0) smoothed_q <= raw_mv;
				end
			end

			if (ctl_q == ibbm_pkg::CS_SMOOTH) smoothed_q <= blend_sat;

			if (out_load)        m_valid_q <= 1'b1;
			else if (m_tready)   m_valid_q <= 1'b0;
		end
	end

	// --- payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			level_q    <= level_new;
			wake_q     <= wake_now;
			sleep_q    <= sleep_now;
			charging_q <= usb;
			blend_q    <= blend_num;
		end
		if (ctl_q == ibbm_pkg::CS_PCT) begin
			pct_upper_q <= !pct_lower;
			if (pct_full)       pct_q <= ibbm_pkg::FULL_PCT;
			else if (pct_empty) pct_q <= '0;
		end
		if (ctl_q == ibbm_pkg::CS_PCT_WAIT && div_done) begin
			pct_q <= pct_upper_q ? (ibbm_pkg::HALF_PCT + div_quo[6:0]) : div_quo[6:0];
		end
		if (out_load) begin
			m_data_q <= {3'b000,
			             charging_q,
			             (smoothed_q != '0) && (smoothed_q < low_mv_q),
			             pct_q,
			             smoothed_q,
			             mask_q,
			             sleep_q,
			             wake_q,
			             level_q,
			             disp_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

@@ rtl/ibbm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ibbm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ibbm_pkg::div_req_t        req,
	output logic                      done,
	output logic [ibbm_pkg::DIV_W-1:0] quotient
);

	logic [ibbm_pkg::DIV_W-1:0] quo_q;
	logic [ibbm_pkg::DVS_W-1:0] rem_q;
	logic [ibbm_pkg::DVS_W-1:0] dvs_q;
	logic [ibbm_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ibbm_pkg::DVS_W:0]   rem_sh;
	logic                       fits;

	assign rem_sh = {rem_q, quo_q[ibbm_pkg::DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ibbm_pkg::CNT_W'(ibbm_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ibbm_pkg::CNT_W'(1);
				if (cnt_q == ibbm_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// shift in one dividend bit, subtract when it fits
			rem_q <= fits ? ibbm_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
			              : rem_sh[ibbm_pkg::DVS_W-1:0];
			quo_q <= {quo_q[ibbm_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
